// ===== hdl/skrt_pkg.sv =====
// Shared constants and codes for the sorted key record table.
package skrt_pkg;

  localparam int CAPACITY = 32;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int NAME_W   = 64;
  localparam int REC_W    = KEY_W + NAME_W;

  typedef enum logic [2:0] {
    OP_INSERT    = 3'd0,
    OP_DELETE    = 3'd1,
    OP_SEARCH    = 3'd2,
    OP_LIST_ASC  = 3'd3,
    OP_LIST_DESC = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

endpackage

// ===== hdl/sorted_key_record_table_unit.sv =====
// Sorted record table: keys ascending in a RAM, one shared compare unit, small sequencer.
// Steps (n = records held, m = records moved): scan, decide, then for insert and delete shift
// m records, m = n-pos on insert and n-pos-1 on delete; insert then writes the new record;
// every request ends with a response. A list reads and returns one record per result and
// waits on out_ready before it reads the next one; one request at a time.
// Throughput is set by the single RAM read port: at most one record touched per cycle.
// Reset clears the record count and the sequencer; the RAM is not cleared (never read past count).
module sorted_key_record_table_unit
  import skrt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [2:0]               op,
  input  logic signed [KEY_W-1:0]  key,
  input  logic [NAME_W-1:0]        name,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               status,
  output logic signed [KEY_W-1:0]  key_res,
  output logic [NAME_W-1:0]        name_res,
  output logic                     last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_PUT,
    S_LIST_RD,
    S_LIST_LD,
    S_OUT
  } state_t;

  state_t                 state;
  logic [CW-1:0]          count;      // records held
  logic [2:0]             req_op;
  logic signed [KEY_W-1:0] req_key;
  logic [NAME_W-1:0]      req_name;
  logic [CW-1:0]          idx;        // RAM read pointer (scan, shift source, list)
  logic                   chk_v;      // read data valid for compare this cycle
  logic                   found;
  logic [CW-1:0]          pos;        // match index, or insert position
  logic [CW-1:0]          moves;      // remaining shift moves / list results
  logic                   step_dn;    // idx walks downward
  logic                   wr_pend;
  logic [AW-1:0]          wr_dst;
  logic [NAME_W-1:0]      hit_name;

  // RAM port
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [REC_W-1:0]       ram_wdata;
  logic [REC_W-1:0]       ram_rdata;

  // Shared compare unit
  logic signed [KEY_W-1:0] rd_key;
  logic                   key_eq;
  logic                   key_lt;

  assign rd_key = ram_rdata[REC_W-1:NAME_W];
  assign key_eq = (rd_key == req_key);
  assign key_lt = (rd_key < req_key);

  assign in_ready = (state == S_IDLE);

  // Shift stage writes the word read last cycle; PUT drops the new record into its slot.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_dst;
    ram_wdata = ram_rdata;
    if (state == S_SHIFT && wr_pend) begin
      ram_we = 1'b1;
    end else if (state == S_PUT) begin
      ram_we    = 1'b1;
      ram_waddr = pos[AW-1:0];
      ram_wdata = {req_key, req_name};
    end
  end

  skrt_ram #(
    .WIDTH(REC_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      chk_v     <= 1'b0;
      wr_pend   <= 1'b0;
      found     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_op   <= op;
            req_key  <= key;
            req_name <= name;
            chk_v    <= 1'b0;
            found    <= 1'b0;
            pos      <= '0;
            case (op)
              OP_INSERT, OP_DELETE, OP_SEARCH: begin
                idx   <= '0;
                state <= S_SCAN;
              end
              OP_LIST_ASC, OP_LIST_DESC: begin
                if (count == '0) begin
                  status    <= ST_EMPTY;
                  key_res   <= '0;
                  name_res  <= '0;
                  last      <= 1'b1;
                  out_valid <= 1'b1;
                  state     <= S_OUT;
                end else begin
                  step_dn <= (op == OP_LIST_DESC);
                  idx     <= (op == OP_LIST_DESC) ? count - CW'(1) : '0;
                  moves   <= count;
                  state   <= S_LIST_RD;
                end
              end
              default: begin
                // undefined op codes are dropped silently
                state <= S_IDLE;
              end
            endcase
          end
        end

        // Pipelined scan: issue one read per cycle, compare the one returning.
        S_SCAN: begin
          if (chk_v && key_eq) begin
            found    <= 1'b1;
            pos      <= idx - CW'(1);
            hit_name <= ram_rdata[NAME_W-1:0];
            chk_v    <= 1'b0;
            state    <= S_DECIDE;
          end else if (idx == count && !chk_v) begin
            state <= S_DECIDE;
          end else begin
            if (chk_v && key_lt) begin
              pos <= pos + CW'(1);
            end
            if (idx < count) begin
              idx   <= idx + CW'(1);
              chk_v <= 1'b1;
            end else begin
              chk_v <= 1'b0;
            end
          end
        end

        S_DECIDE: begin
          last     <= 1'b1;
          wr_pend  <= 1'b0;
          case (req_op)
            OP_INSERT: begin
              key_res  <= '0;
              name_res <= '0;
              if (found) begin
                status    <= ST_DUP;
                out_valid <= 1'b1;
                state     <= S_OUT;
              end else if (count == CW'(CAPACITY)) begin
                status    <= ST_FULL;
                out_valid <= 1'b1;
                state     <= S_OUT;
              end else begin
                // open a hole at pos: move entries pos..count-1 up by one
                step_dn <= 1'b1;
                idx     <= count - CW'(1);
                moves   <= count - pos;
                state   <= S_SHIFT;
              end
            end
            OP_DELETE: begin
              key_res  <= '0;
              name_res <= '0;
              if (count == '0) begin
                status    <= ST_EMPTY;
                out_valid <= 1'b1;
                state     <= S_OUT;
              end else if (!found) begin
                status    <= ST_NOTFOUND;
                out_valid <= 1'b1;
                state     <= S_OUT;
              end else begin
                // close the gap: move entries pos+1..count-1 down by one
                step_dn <= 1'b0;
                idx     <= pos + CW'(1);
                moves   <= count - CW'(1) - pos;
                state   <= S_SHIFT;
              end
            end
            OP_SEARCH: begin
              key_res   <= found ? req_key : '0;
              name_res  <= found ? hit_name : '0;
              status    <= found ? ST_OK : ST_NOTFOUND;
              out_valid <= 1'b1;
              state     <= S_OUT;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end

        S_SHIFT: begin
          if (moves != '0) begin
            idx     <= step_dn ? idx - CW'(1) : idx + CW'(1);
            wr_dst  <= step_dn ? AW'(idx + CW'(1)) : AW'(idx - CW'(1));
            moves   <= moves - CW'(1);
            wr_pend <= 1'b1;
          end else begin
            wr_pend <= 1'b0;
          end
          if (moves == '0 && !wr_pend) begin
            if (step_dn) begin
              state <= S_PUT;
            end else begin
              count     <= count - CW'(1);
              status    <= ST_OK;
              key_res   <= req_key;
              out_valid <= 1'b1;
              state     <= S_OUT;
            end
          end
        end

        S_PUT: begin
          count     <= count + CW'(1);
          status    <= ST_OK;
          out_valid <= 1'b1;
          state     <= S_OUT;
        end

        S_LIST_RD: begin
          state <= S_LIST_LD;
        end

        S_LIST_LD: begin
          status    <= ST_OK;
          key_res   <= rd_key;
          name_res  <= ram_rdata[NAME_W-1:0];
          last      <= (moves == CW'(1));
          out_valid <= 1'b1;
          state     <= S_OUT;
        end

        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= S_IDLE;
            end else begin
              idx   <= step_dn ? idx - CW'(1) : idx + CW'(1);
              moves <= moves - CW'(1);
              state <= S_LIST_RD;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("record count above capacity");

  // one request at a time: no new request while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  // the final result hands control back to the input side
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> in_ready)
    else $error("not ready after final result");

  // only list results come in a run, and those are always good
  a_run_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (status == ST_OK))
    else $error("non-final result with bad status");

  // count changes only as a request completes, with its result pending
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (state == S_OUT))
    else $error("record count changed outside completion");

endmodule

// ===== hdl/skrt_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
module skrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
